// File: design/adsr_pkg.sv
// Package for the linear ADSR envelope generator: widths, reset values,
// envelope phase codes and register indexes.
// Used by adsr_envelope_generator and adsr_checker; depends on nothing.
package adsr_pkg;

  localparam int COUNT_BITS = 17;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [15:0] FULL_SCALE = 16'd32768;

  // Dividend of a ramp: level difference (at most 2^15) times the count.
  localparam int DIV_BITS = 15 + COUNT_BITS;
  localparam int ITER_W   = $clog2(DIV_BITS);

  // Shared multiplier operands: A is a signed sample or a level difference,
  // B is a count or an unsigned level, each with a sign bit.
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int ADDR_W = 4;

  localparam logic [15:0] RST_ATTACK  = 16'd19845;
  localparam logic [15:0] RST_DECAY   = 16'd220;
  localparam logic [15:0] RST_SUSTAIN = 16'd32768;
  localparam logic [15:0] RST_RELEASE = 16'd220;
  localparam logic [15:0] RST_START   = 16'd2294;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_t;

endpackage

// File: design/adsr_envelope_generator.sv
// Linear ADSR envelope generator: one sample and gate bit in, one shaped
// sample and envelope level out. Ramps use one shared multiplier and a
// bit-serial restoring divider. Depends on adsr_pkg.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  in_sample_in[15:0] s, in_gate
//   out      output     out_valid/out_ready out_sample_out[15:0] s, out_level[15:0]
//   cfg      input      psel/penable/pwrite/pready  paddr[3:0], pwdata[31:0]
//
// A ramped item steps through taking the item, one multiply, one divider
// step per quotient bit, clamping the level and multiplying the sample. A
// held or sustained level goes from taking the item straight to the sample
// multiply.
// The input is ready whenever the sequencer is idle, even while a result
// waits in the output register; the final step waits for that register.
// rst_n is synchronous and restores register defaults and envelope state.
module adsr_envelope_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_sample_in,
  input  logic                             in_gate,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               out_sample_out,
  output logic [15:0]                      out_level,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int CB     = adsr_pkg::COUNT_BITS;
  localparam int DB     = adsr_pkg::DIV_BITS;
  localparam int SH_W   = adsr_pkg::PROD_W - 15;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-32768);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LEVEL,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [15:0] atk_r, dec_r, sus_cfg_r, rel_r;

  // Envelope state.
  adsr_pkg::phase_t phase_r;
  logic [15:0]      env_r;
  logic [15:0]      start_r;
  logic [CB-1:0]    count_r;
  logic             last_gate_r;

  // Sequencer and working registers.
  state_t                 state_r;
  logic [15:0]            from_r;
  logic                   up_r;
  logic [15:0]            diff_r;
  logic [CB-1:0]          num_r;
  logic [15:0]            den_r;
  logic signed [15:0]     sample_r;
  logic [DB-1:0]          quo_r;
  logic [15:0]            rem_r;
  logic [adsr_pkg::ITER_W-1:0] iter_r;
  logic                   out_valid_r;
  logic signed [15:0]     out_sample_r;
  logic [15:0]            out_level_r;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  logic                 cfg_wr;
  adsr_pkg::reg_idx_t   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = adsr_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atk_r     <= adsr_pkg::RST_ATTACK;
      dec_r     <= adsr_pkg::RST_DECAY;
      sus_cfg_r <= adsr_pkg::RST_SUSTAIN;
      rel_r     <= adsr_pkg::RST_RELEASE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        adsr_pkg::REG_ATTACK:  atk_r     <= pwdata[15:0];
        adsr_pkg::REG_DECAY:   dec_r     <= pwdata[15:0];
        adsr_pkg::REG_SUSTAIN: sus_cfg_r <= pwdata[15:0];
        adsr_pkg::REG_RELEASE: rel_r     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      adsr_pkg::REG_ATTACK:  prdata = {16'd0, atk_r};
      adsr_pkg::REG_DECAY:   prdata = {16'd0, dec_r};
      adsr_pkg::REG_SUSTAIN: prdata = {16'd0, sus_cfg_r};
      adsr_pkg::REG_RELEASE: prdata = {16'd0, rel_r};
      default:               prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Phase decisions for the item on the input
  // ---------------------------------------------------------------------
  logic               in_acc;
  logic               gate_edge;
  adsr_pkg::phase_t   ph_e, phase_nxt;
  logic [CB-1:0]      cnt_e, cnt_base, count_nxt;
  logic [15:0]        st_e, start_nxt;
  logic [15:0]        sus;
  logic [15:0]        to_v, den_v, env_hold;
  logic               ramp_go;
  logic               ramp_up;
  logic [15:0]        ramp_diff;
  logic [31:0]        cnt32;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    gate_edge = (in_gate != last_gate_r);
    if (gate_edge) begin
      ph_e  = in_gate ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_RELEASE;
      cnt_e = '0;
      st_e  = env_r;
    end else begin
      ph_e  = phase_r;
      cnt_e = count_r;
      st_e  = start_r;
    end
    sus   = (sus_cfg_r > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE : sus_cfg_r;
    cnt32 = 32'(cnt_e);

    phase_nxt = ph_e;
    cnt_base  = cnt_e;
    start_nxt = st_e;
    ramp_go   = 1'b0;
    to_v      = 16'd0;
    den_v     = 16'd1;
    env_hold  = env_r;

    case (ph_e)
      adsr_pkg::PH_ATTACK: begin
        if (atk_r == 16'd0) begin
          // Zero attack goes straight to decay and keeps the level.
          start_nxt = adsr_pkg::FULL_SCALE;
          phase_nxt = adsr_pkg::PH_DECAY;
          cnt_base  = '0;
        end else begin
          ramp_go = 1'b1;
          to_v    = adsr_pkg::FULL_SCALE;
          den_v   = atk_r;
          if (cnt32 > 32'(atk_r)) begin
            cnt_base  = '0;
            phase_nxt = adsr_pkg::PH_DECAY;
            start_nxt = adsr_pkg::FULL_SCALE;
          end
        end
      end
      adsr_pkg::PH_DECAY: begin
        if (dec_r == 16'd0) begin
          env_hold  = sus;
          cnt_base  = '0;
          phase_nxt = adsr_pkg::PH_SUSTAIN;
        end else begin
          ramp_go = 1'b1;
          to_v    = sus;
          den_v   = dec_r;
          if (cnt32 > 32'(dec_r)) begin
            cnt_base  = '0;
            phase_nxt = adsr_pkg::PH_SUSTAIN;
          end
        end
      end
      adsr_pkg::PH_SUSTAIN: begin
        env_hold = sus;
      end
      default: begin
        if (cnt32 < 32'(rel_r)) begin
          ramp_go = 1'b1;
          to_v    = 16'd0;
          den_v   = rel_r;
        end else begin
          env_hold = 16'd0;
        end
      end
    endcase

    count_nxt = (cnt_base == adsr_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
    ramp_up   = (to_v >= st_e);
    ramp_diff = ramp_up ? (to_v - st_e) : (st_e - to_v);
  end

  // ---------------------------------------------------------------------
  // Shared multiplier, divider step and level clamp
  // ---------------------------------------------------------------------
  logic signed [adsr_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [adsr_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [adsr_pkg::PROD_W-1:0]   prod;
  logic signed [SH_W-1:0]               shaped;
  logic signed [15:0]                   shaped_sat;

  always_comb begin
    if (state_r == S_MUL) begin
      mul_a = signed'(adsr_pkg::MUL_A_W'(diff_r));
      mul_b = signed'(adsr_pkg::MUL_B_W'(num_r));
    end else begin
      mul_a = adsr_pkg::MUL_A_W'(sample_r);
      mul_b = signed'(adsr_pkg::MUL_B_W'(env_r));
    end
    prod   = mul_a * mul_b;
    shaped = prod[adsr_pkg::PROD_W-1:15];
    if (shaped > SAT_HI)
      shaped_sat = 16'sd32767;
    else if (shaped < SAT_LO)
      shaped_sat = -16'sd32768;
    else
      shaped_sat = shaped[15:0];
  end

  logic [16:0] div_sh;
  logic        div_take;
  logic [16:0] div_diff;

  assign div_sh   = {rem_r, quo_r[DB-1]};
  assign div_take = (div_sh >= {1'b0, den_r});
  assign div_diff = div_sh - {1'b0, den_r};

  logic [DB:0]  lvl_sum;
  logic [15:0]  lvl_v;

  always_comb begin
    lvl_sum = (DB+1)'(from_r) + (DB+1)'(quo_r);
    if (up_r) begin
      lvl_v = (lvl_sum > (DB+1)'(adsr_pkg::FULL_SCALE)) ? adsr_pkg::FULL_SCALE
                                                         : lvl_sum[15:0];
    end else begin
      lvl_v = (quo_r > DB'(from_r)) ? 16'd0 : (from_r - quo_r[15:0]);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= adsr_pkg::PH_RELEASE;
      env_r       <= 16'd0;
      start_r     <= adsr_pkg::RST_START;
      count_r     <= '0;
      last_gate_r <= 1'b0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            phase_r     <= phase_nxt;
            count_r     <= count_nxt;
            start_r     <= start_nxt;
            last_gate_r <= in_gate;
            sample_r    <= in_sample_in;
            from_r      <= st_e;
            up_r        <= ramp_up;
            diff_r      <= ramp_diff;
            num_r       <= cnt_e;
            den_r       <= den_v;
            if (ramp_go) begin
              state_r <= S_MUL;
            end else begin
              env_r   <= env_hold;
              state_r <= S_OUT;
            end
          end
        end
        S_MUL: begin
          quo_r   <= prod[DB-1:0];
          rem_r   <= 16'd0;
          iter_r  <= adsr_pkg::ITER_W'(DB - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_take) begin
            rem_r <= div_diff[15:0];
            quo_r <= {quo_r[DB-2:0], 1'b1};
          end else begin
            rem_r <= div_sh[15:0];
            quo_r <= {quo_r[DB-2:0], 1'b0};
          end
          if (iter_r == '0)
            state_r <= S_LEVEL;
          else
            iter_r <= iter_r - 1'b1;
        end
        S_LEVEL: begin
          env_r   <= lvl_v;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_sample_r <= shaped_sat;
            out_level_r  <= env_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_level      = out_level_r;

endmodule

// File: design/adsr_checker.sv
// Port-level checks for the ADSR envelope generator, bound to its top level.
// Depends on adsr_pkg and adsr_envelope_generator.
module adsr_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample_out,
  input logic [15:0]        out_level
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) && $stable(out_level))
    else $error("result item changed while stalled");

  // The level never exceeds full scale.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= adsr_pkg::FULL_SCALE)
    else $error("envelope level above full scale");

  // A silent envelope gives a silent sample.
  a_silence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level == 16'd0 |-> out_sample_out == 16'sd0)
    else $error("non-zero sample at zero level");

  // Once an item is taken the block is busy with it and drops its input ready.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an item was taken");

endmodule

bind adsr_envelope_generator adsr_port_checker u_adsr_checker (.*);

// File: tb/adsr_checker.sv
// Checker for the ADSR envelope generator: it watches the register port and both item
// channels, predicts every result and compares it with what the block delivers.
// Depends on adsr_pkg.
module adsr_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [15:0]            in_sample_in,
  input  logic                          in_gate,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [15:0]            out_sample_out,
  input  logic [15:0]                   out_level,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [adsr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output int                            error_count,
  output int                            pending
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic [15:0]        level;
  } shaped_t;

  // Register copies, written as the block sees them.
  logic [15:0] attack_len;
  logic [15:0] decay_len;
  logic [15:0] sustain_lvl;
  logic [15:0] release_len;

  // Envelope state of the prediction.
  adsr_pkg::phase_t                env_phase;
  logic [15:0]                     env_lvl;
  logic [15:0]                     start_lvl;
  logic [adsr_pkg::COUNT_BITS-1:0] ramp_count;
  logic                            last_gate;

  shaped_t expected_q[$];
  int      n_errors;

  // from + (to - from) * num / den with the ratio truncated, clamped to 0..full scale.
  function automatic logic [15:0] ramp_level(input logic [15:0] from, input logic [15:0] to,
                                             input logic [adsr_pkg::COUNT_BITS-1:0] num,
                                             input logic [15:0] den);
    longint mag;
    longint v;
    if (to >= from) begin
      mag = (longint'(to) - longint'(from)) * longint'(num) / longint'(den);
      v = longint'(from) + mag;
    end else begin
      mag = (longint'(from) - longint'(to)) * longint'(num) / longint'(den);
      v = longint'(from) - mag;
    end
    if (v < 0) return 16'd0;
    if (v > longint'(adsr_pkg::FULL_SCALE)) return adsr_pkg::FULL_SCALE;
    return v[15:0];
  endfunction

  task automatic shape_sample(input logic signed [15:0] smp, input logic g,
                              output shaped_t res);
    logic [15:0] sus;
    longint      prod;
    longint      shaped;
    sus = (sustain_lvl > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE : sustain_lvl;
    if (g != last_gate) begin
      env_phase  = g ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_RELEASE;
      ramp_count = '0;
      start_lvl  = env_lvl;
    end
    last_gate = g;

    case (env_phase)
      adsr_pkg::PH_ATTACK: begin
        // With no attack the level is held for this item and decay starts from full scale.
        if (attack_len == 16'd0) begin
          start_lvl  = adsr_pkg::FULL_SCALE;
          env_phase  = adsr_pkg::PH_DECAY;
          ramp_count = '0;
        end else begin
          env_lvl = ramp_level(start_lvl, adsr_pkg::FULL_SCALE, ramp_count, attack_len);
          if (ramp_count > attack_len) begin
            ramp_count = '0;
            env_phase  = adsr_pkg::PH_DECAY;
            start_lvl  = adsr_pkg::FULL_SCALE;
          end
        end
      end
      adsr_pkg::PH_DECAY: begin
        if (decay_len == 16'd0) begin
          env_lvl    = sus;
          ramp_count = '0;
          env_phase  = adsr_pkg::PH_SUSTAIN;
        end else begin
          env_lvl = ramp_level(start_lvl, sus, ramp_count, decay_len);
          if (ramp_count > decay_len) begin
            ramp_count = '0;
            env_phase  = adsr_pkg::PH_SUSTAIN;
          end
        end
      end
      adsr_pkg::PH_SUSTAIN: begin
        env_lvl = sus;
      end
      default: begin
        if (ramp_count < release_len)
          env_lvl = ramp_level(start_lvl, 16'd0, ramp_count, release_len);
        else
          env_lvl = 16'd0;
      end
    endcase

    if (ramp_count != adsr_pkg::COUNT_MAX) ramp_count = ramp_count + 1'b1;

    // The arithmetic shift floors, as the block's scaling does.
    prod   = longint'(smp) * longint'(env_lvl);
    shaped = prod >>> 15;
    if (shaped > 32767) shaped = 32767;
    if (shaped < -32768) shaped = -32768;
    res.sample = shaped[15:0];
    res.level  = env_lvl;
  endtask

  task automatic note_failure(input string what);
    n_errors++;
    if (n_errors <= 10) $display("%s", what);
  endtask

  always @(posedge clk) begin
    shaped_t want;
    if (!rst_n) begin
      attack_len  = adsr_pkg::RST_ATTACK;
      decay_len   = adsr_pkg::RST_DECAY;
      sustain_lvl = adsr_pkg::RST_SUSTAIN;
      release_len = adsr_pkg::RST_RELEASE;
      env_phase   = adsr_pkg::PH_RELEASE;
      env_lvl     = 16'd0;
      start_lvl   = adsr_pkg::RST_START;
      ramp_count  = '0;
      last_gate   = 1'b0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (adsr_pkg::reg_idx_t'(paddr[adsr_pkg::ADDR_W-1:2]))
          adsr_pkg::REG_ATTACK:  attack_len  = pwdata[15:0];
          adsr_pkg::REG_DECAY:   decay_len   = pwdata[15:0];
          adsr_pkg::REG_SUSTAIN: sustain_lvl = pwdata[15:0];
          adsr_pkg::REG_RELEASE: release_len = pwdata[15:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result: sample %0d level %0d",
                                 out_sample_out, out_level));
        end else begin
          want = expected_q.pop_front();
          if (want.sample !== out_sample_out || want.level !== out_level)
            note_failure($sformatf(
              "mismatch: sample exp %0d got %0d, level exp %0d got %0d",
              want.sample, out_sample_out, want.level, out_level));
        end
      end

      if (in_valid && in_ready) begin
        shape_sample(in_sample_in, in_gate, want);
        expected_q.push_back(want);
      end
    end
    pending     <= expected_q.size();
    error_count <= n_errors;
  end

endmodule

// File: tb/tb_adsr_envelope_generator.sv
// Top of the ADSR envelope generator testbench: clock, reset, register writes and
// item stimulus with random idling; results are checked by adsr_checker.
// Depends on adsr_pkg, adsr_envelope_generator and adsr_checker.
module tb_adsr_envelope_generator;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int HOLD_OFF_LEN   = 500;
  localparam int TAIL_CYCLES    = 48;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [15:0]            in_sample_in;
  logic                          in_gate;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [15:0]            out_sample_out;
  logic [15:0]                   out_level;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [adsr_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  int error_count;
  int pending;
  int cycle_count = 0;

  // Set by the item process and read by the receiver.
  bit idle_en     = 1'b1;
  bit hold_off_go = 1'b0;

  logic [15:0] cur_attack;
  logic [15:0] cur_decay;
  logic [15:0] cur_release;

  adsr_envelope_generator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_gate        (in_gate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_level      (out_level),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  adsr_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_gate        (in_gate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_level      (out_level),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .error_count    (error_count),
    .pending        (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random back-pressure, and one long hold-off on request.
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end
      out_ready <= !idle_en || ($urandom_range(0, 99) >= 25);
    end
  end

  function automatic logic signed [15:0] pick_sample();
    if ($urandom_range(0, 9) != 0) return 16'($urandom);
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'sh0001;
    endcase
  endfunction

  function automatic logic [15:0] pick_sustain();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return adsr_pkg::FULL_SCALE;
      2:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic send_item(input logic signed [15:0] smp, input logic g);
    while (idle_en && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    in_gate      <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input adsr_pkg::reg_idx_t idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_envelope(input logic [15:0] a, input logic [15:0] d,
                                  input logic [15:0] s, input logic [15:0] r);
    write_reg(adsr_pkg::REG_ATTACK, a);
    write_reg(adsr_pkg::REG_DECAY, d);
    write_reg(adsr_pkg::REG_SUSTAIN, s);
    write_reg(adsr_pkg::REG_RELEASE, r);
    cur_attack  = a;
    cur_decay   = d;
    cur_release = r;
  endtask

  // Registers may only change once every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly notes (gate held for a random run of up to attack + decay + 12 items,
  // at most 80, then a release), with short runs of random gate noise between.
  task automatic play_notes(input int n_items);
    int done;
    int hi;
    int on_len;
    int off_len;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        hi = int'(cur_attack) + int'(cur_decay) + 12;
        if (hi > 80) hi = 80;
        on_len = $urandom_range(1, hi);
        hi = int'(cur_release) + 10;
        if (hi > 80) hi = 80;
        off_len = $urandom_range(1, hi);
        repeat (on_len) send_item(pick_sample(), 1'b1);
        repeat (off_len) send_item(pick_sample(), 1'b0);
        done += on_len + off_len;
      end else begin
        on_len = $urandom_range(1, 6);
        repeat (on_len) send_item(pick_sample(), 1'($urandom));
        done += on_len;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    in_gate      = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cur_attack   = adsr_pkg::RST_ATTACK;
    cur_decay    = adsr_pkg::RST_DECAY;
    cur_release  = adsr_pkg::RST_RELEASE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the envelope is releasing from its small start level.
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'shFFFF, 1'b0);
    send_item(16'sh0000, 1'b1);
    send_item(16'sh7FFF, 1'b1);
    drain();

    // No attack, sustain written above full scale, no release.
    program_envelope(16'd0, 16'd3, 16'd40000, 16'd0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh7FFF, 1'b1);
    drain();

    // No decay and zero sustain; the short attack overshoots at its last step.
    program_envelope(16'd2, 16'd0, 16'd0, 16'd65535);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b0);
    drain();

    program_envelope(16'd65535, 16'd65535, adsr_pkg::FULL_SCALE, 16'd5);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh0001, 1'b0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      idle_en = 1'b1;
      case (ph)
        2:       program_envelope(16'd1, 16'd1, adsr_pkg::FULL_SCALE, 16'd1);
        4:       program_envelope(16'd65535, 16'd65535, 16'd0, 16'd65535);
        5:       program_envelope(16'd0, 16'd0, 16'($urandom_range(32769, 65535)), 16'd0);
        default: program_envelope(16'($urandom_range(0, 24)), 16'($urandom_range(1, 24)),
                                  pick_sustain(), 16'($urandom_range(0, 24)));
      endcase
      if (ph == 1) idle_en = 1'b0;
      // The receiver stops for a long while so that the block backs up.
      if (ph == 3) hold_off_go = 1'b1;
      play_notes((ph == 4 || ph == 5) ? 100 : 150);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
design/adsr_pkg.sv
design/adsr_envelope_generator.sv
design/adsr_checker.sv
tb/adsr_checker.sv
tb/tb_adsr_envelope_generator.sv
